>>> hw/rtl/wasm_pkg.sv
// shared opcodes, status codes and field widths of the i32 stack executor
package wasm_pkg;

   localparam int OP_W     = 5;
   localparam int DATA_W   = 32;
   localparam int LIDX_W   = 5;
   localparam int LDEPTH_W = 6;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 9;
   localparam int CFG_W    = 5;
   localparam int KIND_W   = 2;

   localparam logic [OP_W-1:0] OP_NOP         = 5'd0;
   localparam logic [OP_W-1:0] OP_TRAP        = 5'd1;
   localparam logic [OP_W-1:0] OP_BLK         = 5'd2;
   localparam logic [OP_W-1:0] OP_LOOP        = 5'd3;
   localparam logic [OP_W-1:0] OP_IF          = 5'd4;
   localparam logic [OP_W-1:0] OP_ELSE        = 5'd5;
   localparam logic [OP_W-1:0] OP_END         = 5'd6;
   localparam logic [OP_W-1:0] OP_BR          = 5'd7;
   localparam logic [OP_W-1:0] OP_BR_COND     = 5'd8;
   localparam logic [OP_W-1:0] OP_RET         = 5'd9;
   localparam logic [OP_W-1:0] OP_DROP        = 5'd10;
   localparam logic [OP_W-1:0] OP_LGET        = 5'd11;
   localparam logic [OP_W-1:0] OP_LSET        = 5'd12;
   localparam logic [OP_W-1:0] OP_LTEE        = 5'd13;
   localparam logic [OP_W-1:0] OP_CONST       = 5'd14;
   localparam logic [OP_W-1:0] OP_EQZ         = 5'd15;
   localparam logic [OP_W-1:0] OP_EQ          = 5'd16;
   localparam logic [OP_W-1:0] OP_NE          = 5'd17;
   localparam logic [OP_W-1:0] OP_LT_S        = 5'd18;
   localparam logic [OP_W-1:0] OP_GT_S        = 5'd19;
   localparam logic [OP_W-1:0] OP_LE_S        = 5'd20;
   localparam logic [OP_W-1:0] OP_GE_S        = 5'd21;
   localparam logic [OP_W-1:0] OP_ADD         = 5'd22;
   localparam logic [OP_W-1:0] OP_SUB         = 5'd23;
   localparam logic [OP_W-1:0] OP_MUL         = 5'd24;
   localparam logic [OP_W-1:0] OP_DIV_S       = 5'd25;
   localparam logic [OP_W-1:0] OP_REM_S       = 5'd26;
   localparam logic [OP_W-1:0] OP_AND         = 5'd27;
   localparam logic [OP_W-1:0] OP_OR          = 5'd28;

   localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_RETURNED    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_UNREACHABLE = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_LABEL_OVF   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_COND_UNDER  = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_UNKNOWN_OP  = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_DIV_ZERO    = 3'd6;

   localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IF    = 2'd2;

endpackage

>>> hw/rtl/wasm_if.sv
// instruction and result channel interfaces
interface wasm_req_if;
   import wasm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            op;
   logic signed [DATA_W-1:0]   imm_value;
   logic [LIDX_W-1:0]          local_index;
   logic [LDEPTH_W-1:0]        label_depth;
   logic [ADDR_W-1:0]          end_addr;
   logic [ADDR_W-1:0]          loop_addr;
   logic [ADDR_W-1:0]          else_addr;
   logic                       has_else;

   modport source (output valid, op, imm_value, local_index, label_depth, end_addr,
                   loop_addr, else_addr, has_else, input ready);
   modport sink (input valid, op, imm_value, local_index, label_depth, end_addr,
                 loop_addr, else_addr, has_else, output ready);
endinterface

interface wasm_rsp_if;
   import wasm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic                       redirect;
   logic [ADDR_W-1:0]          jump_target;
   logic signed [DATA_W-1:0]   return_value;
   logic [DEPTH_W-1:0]         depth_now;

   modport source (output valid, status, redirect, jump_target, return_value, depth_now,
                   input ready);
   modport sink (input valid, status, redirect, jump_target, return_value, depth_now,
                 output ready);
endinterface

>>> hw/rtl/wasm_div.sv
// iterative signed divider, one quotient bit per cycle
module wasm_div #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic             neg_q_ff, neg_q_in;
   logic             neg_r_ff, neg_r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [W:0]       trial;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in   = divisor[W-1] ? (~divisor + 1'b1) : divisor;
         neg_q_in = dividend[W-1] ^ divisor[W-1];
         neg_r_in = dividend[W-1];
         cnt_in   = CNT_W'(W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial[W] ? {rem_ff[W-2:0], quo_ff[W-1]} : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign busy      = busy_ff;
   assign quotient  = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign remainder = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;

endmodule

>>> hw/rtl/wasm_i32_stack_executor.sv
// top level of the i32 stack executor
// each item: accept with stack and label memory read in ST_IDLE, then execute and write back in ST_EXEC or ST_DIV
// div_s and rem_s with a nonzero divisor go through ST_DIV and the 1-bit-per-cycle divider
// a new item is taken only in ST_IDLE, once the previous item has been written back
// the result register lets the next item in while a result waits
// reset clears depth, label count, halt, locals and locals_in_use; stack memories keep contents
module wasm_i32_stack_executor #(
   parameter int STACK_DEPTH = 256,
   parameter int LOCAL_SLOTS = 16,
   parameter int LABEL_DEPTH = 32,
   parameter int ADDR_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [wasm_pkg::CFG_W-1:0]  csr_wr_data,
   wasm_req_if.sink                    req_ch,
   wasm_rsp_if.source                  rsp_ch
);
   import wasm_pkg::*;

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int LC_W  = $clog2(LABEL_DEPTH + 1);
   localparam int LA_W  = $clog2(LABEL_DEPTH);
   localparam int LI_W  = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
   localparam int AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int LAB_W = KIND_W + 2 * AW + SP_W;
   localparam int DW    = ((LC_W > LDEPTH_W) ? LC_W : LDEPTH_W) + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [LC_W-1:0]     lc_ff, lc_in;
   logic                halted_ff, halted_in;
   logic [CFG_W-1:0]    locals_in_use_ff;
   logic [DATA_W-1:0]   locals_ff [LOCAL_SLOTS];

   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
   logic [LAB_W-1:0]    label_mem [LABEL_DEPTH];
   logic [DATA_W-1:0]   tos_ff, nos_ff;
   logic [LAB_W-1:0]    lab_rd_ff;

   logic [OP_W-1:0]     op_ff;
   logic [DATA_W-1:0]   imm_ff;
   logic [LIDX_W-1:0]   li_ff;
   logic [LDEPTH_W-1:0] ld_ff;
   logic [AW-1:0]       ea_ff, la_ff, xa_ff;
   logic                he_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_redirect_ff;
   logic [ADDR_W-1:0]   rsp_target_ff;
   logic [DATA_W-1:0]   rsp_ret_ff;
   logic [DEPTH_W-1:0]  rsp_depth_ff;

   logic                req_fire, out_free, commit, div_need, div_start, div_busy;
   logic [SP_W-1:0]     sp_m1, sp_m2;
   logic [DW-1:0]       rd_lab_idx, ex_lab_idx;
   logic [KIND_W-1:0]   lab_kind;
   logic [AW-1:0]       lab_cont, lab_start;
   logic [SP_W-1:0]     lab_height;
   logic                local_ok, lab_full, br_is_ret, br_loop;
   logic [LI_W-1:0]     loc_idx;
   logic [DATA_W-1:0]   alu_r, div_q, div_r;

   logic [STATUS_W-1:0] status_c;
   logic                redir_c;
   logic [AW-1:0]       target_c;
   logic [DATA_W-1:0]   ret_c;
   logic                stk_we, lab_we, loc_we;
   logic [SA_W-1:0]     stk_waddr;
   logic [DATA_W-1:0]   stk_wdata, loc_wdata;
   logic [LAB_W-1:0]    lab_wdata;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign sp_m1      = sp_ff - 1'b1;
   assign sp_m2      = sp_ff - 2'd2;
   assign rd_lab_idx = (req_ch.op == OP_ELSE) ? (DW'(lc_ff) - 1'b1)
                                              : (DW'(lc_ff) - 1'b1 - DW'(req_ch.label_depth));
   assign ex_lab_idx = DW'(lc_ff) - 1'b1 - DW'(ld_ff);

   assign lab_kind   = lab_rd_ff[LAB_W-1 -: KIND_W];
   assign lab_cont   = lab_rd_ff[2*AW+SP_W-1 -: AW];
   assign lab_start  = lab_rd_ff[AW+SP_W-1 -: AW];
   assign lab_height = lab_rd_ff[SP_W-1:0];
   assign br_is_ret  = DW'(ld_ff) >= DW'(lc_ff);
   assign br_loop    = (lab_kind == KIND_LOOP);

   assign local_ok = (CFG_W'(li_ff) < locals_in_use_ff) && (32'(li_ff) < LOCAL_SLOTS);
   assign loc_idx  = LI_W'(li_ff);
   assign lab_full = (32'(lc_ff) >= LABEL_DEPTH);

   assign div_need = !halted_ff && ((op_ff == OP_DIV_S) || (op_ff == OP_REM_S))
                     && (32'(sp_ff) >= 2) && (tos_ff != '0);

   always_comb begin
      case (op_ff) inside
         OP_EQ:    alu_r = DATA_W'(nos_ff == tos_ff);
         OP_NE:    alu_r = DATA_W'(nos_ff != tos_ff);
         OP_LT_S:  alu_r = DATA_W'($signed(nos_ff) < $signed(tos_ff));
         OP_GT_S:  alu_r = DATA_W'($signed(nos_ff) > $signed(tos_ff));
         OP_LE_S:  alu_r = DATA_W'($signed(nos_ff) <= $signed(tos_ff));
         OP_GE_S:  alu_r = DATA_W'($signed(nos_ff) >= $signed(tos_ff));
         OP_ADD:   alu_r = nos_ff + tos_ff;
         OP_SUB:   alu_r = nos_ff - tos_ff;
         OP_MUL:   alu_r = nos_ff * tos_ff;
         OP_DIV_S: alu_r = (tos_ff == '0) ? '0 : div_q;
         OP_REM_S: alu_r = (tos_ff == '0) ? '0 : div_r;
         OP_AND:   alu_r = nos_ff & tos_ff;
         default:  alu_r = nos_ff | tos_ff;
      endcase
   end

   always_comb begin
      sp_in     = sp_ff;
      lc_in     = lc_ff;
      halted_in = halted_ff;
      status_c  = STAT_OK;
      redir_c   = 1'b0;
      target_c  = '0;
      ret_c     = '0;
      stk_we    = 1'b0;
      stk_waddr = sp_ff[SA_W-1:0];
      stk_wdata = '0;
      lab_we    = 1'b0;
      lab_wdata = '0;
      loc_we    = 1'b0;
      loc_wdata = tos_ff;
      if (!halted_ff) begin
         case (op_ff) inside
            OP_NOP: ;
            OP_TRAP: begin
               status_c  = STAT_UNREACHABLE;
               halted_in = 1'b1;
            end
            OP_BLK, OP_LOOP: begin
               if (lab_full) begin
                  status_c  = STAT_LABEL_OVF;
                  halted_in = 1'b1;
               end else begin
                  lab_we    = 1'b1;
                  lab_wdata = {(op_ff == OP_LOOP) ? KIND_LOOP : KIND_BLOCK, ea_ff, la_ff, sp_ff};
                  lc_in     = lc_ff + 1'b1;
               end
            end
            OP_IF: begin
               if (sp_ff == '0) begin
                  status_c  = STAT_COND_UNDER;
                  halted_in = 1'b1;
               end else begin
                  sp_in = sp_m1;
                  if ((tos_ff != '0) || he_ff) begin
                     if (lab_full) begin
                        status_c  = STAT_LABEL_OVF;
                        halted_in = 1'b1;
                     end else begin
                        lab_we    = 1'b1;
                        lab_wdata = {KIND_IF, ea_ff, {AW{1'b0}}, sp_m1};
                        lc_in     = lc_ff + 1'b1;
                        if (tos_ff == '0) begin
                           redir_c  = 1'b1;
                           target_c = xa_ff;
                        end
                     end
                  end else begin
                     redir_c  = 1'b1;
                     target_c = ea_ff;
                  end
               end
            end
            OP_ELSE: begin
               if (lc_ff != '0) begin
                  lc_in    = lc_ff - 1'b1;
                  redir_c  = 1'b1;
                  target_c = lab_cont;
               end
            end
            OP_END: begin
               if (lc_ff != '0) begin
                  lc_in = lc_ff - 1'b1;
               end else begin
                  status_c  = STAT_RETURNED;
                  halted_in = 1'b1;
                  ret_c     = (sp_ff != '0) ? tos_ff : '0;
               end
            end
            OP_BR: begin
               if (br_is_ret) begin
                  status_c  = STAT_RETURNED;
                  halted_in = 1'b1;
                  ret_c     = (sp_ff != '0) ? tos_ff : '0;
               end else begin
                  redir_c  = 1'b1;
                  target_c = br_loop ? lab_start : lab_cont;
                  sp_in    = lab_height;
                  lc_in    = LC_W'(ex_lab_idx + DW'(br_loop));
               end
            end
            OP_BR_COND: begin
               if (sp_ff == '0) begin
                  status_c  = STAT_COND_UNDER;
                  halted_in = 1'b1;
               end else begin
                  sp_in = sp_m1;
                  if (tos_ff != '0) begin
                     if (br_is_ret) begin
                        status_c  = STAT_RETURNED;
                        halted_in = 1'b1;
                        ret_c     = (sp_m1 != '0) ? nos_ff : '0;
                     end else begin
                        redir_c  = 1'b1;
                        target_c = br_loop ? lab_start : lab_cont;
                        sp_in    = lab_height;
                        lc_in    = LC_W'(ex_lab_idx + DW'(br_loop));
                     end
                  end
               end
            end
            OP_RET: begin
               status_c  = STAT_RETURNED;
               halted_in = 1'b1;
               ret_c     = (sp_ff != '0) ? tos_ff : '0;
            end
            OP_DROP: begin
               if (sp_ff != '0) begin
                  sp_in = sp_m1;
               end
            end
            OP_LGET: begin
               if (local_ok && (32'(sp_ff) < STACK_DEPTH)) begin
                  stk_we    = 1'b1;
                  stk_wdata = locals_ff[loc_idx];
                  sp_in     = sp_ff + 1'b1;
               end
            end
            OP_LSET: begin
               if (local_ok && (sp_ff != '0)) begin
                  loc_we = 1'b1;
                  sp_in  = sp_m1;
               end
            end
            OP_LTEE: begin
               if (local_ok && (sp_ff != '0)) begin
                  loc_we = 1'b1;
               end
            end
            OP_CONST: begin
               if (32'(sp_ff) < STACK_DEPTH) begin
                  stk_we    = 1'b1;
                  stk_wdata = imm_ff;
                  sp_in     = sp_ff + 1'b1;
               end
            end
            OP_EQZ: begin
               if (sp_ff != '0) begin
                  stk_we    = 1'b1;
                  stk_waddr = sp_m1[SA_W-1:0];
                  stk_wdata = DATA_W'(tos_ff == '0);
               end
            end
            OP_EQ, OP_NE, OP_LT_S, OP_GT_S, OP_LE_S, OP_GE_S, OP_ADD, OP_SUB, OP_MUL,
            OP_DIV_S, OP_REM_S, OP_AND, OP_OR: begin
               if (32'(sp_ff) >= 2) begin
                  sp_in     = sp_m1;
                  stk_we    = 1'b1;
                  stk_waddr = sp_m2[SA_W-1:0];
                  stk_wdata = alu_r;
                  if (((op_ff == OP_DIV_S) || (op_ff == OP_REM_S)) && (tos_ff == '0)) begin
                     status_c = STAT_DIV_ZERO;
                  end
               end
            end
            default: begin
               status_c  = STAT_UNKNOWN_OP;
               halted_in = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      commit    = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (div_need) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!div_busy && out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   wasm_div #(.W(DATA_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (nos_ff),
      .divisor   (tos_ff),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_ff @(posedge clock) begin
      if (commit && stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (req_fire) begin
         tos_ff <= stack_mem[sp_m1[SA_W-1:0]];
         nos_ff <= stack_mem[sp_m2[SA_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (commit && lab_we) begin
         label_mem[lc_ff[LA_W-1:0]] <= lab_wdata;
      end
      if (req_fire) begin
         lab_rd_ff <= label_mem[rd_lab_idx[LA_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_ch.op;
         imm_ff <= req_ch.imm_value;
         li_ff  <= req_ch.local_index;
         ld_ff  <= req_ch.label_depth;
         ea_ff  <= req_ch.end_addr[AW-1:0];
         la_ff  <= req_ch.loop_addr[AW-1:0];
         xa_ff  <= req_ch.else_addr[AW-1:0];
         he_ff  <= req_ch.has_else;
      end
      if (commit) begin
         rsp_status_ff   <= status_c;
         rsp_redirect_ff <= redir_c;
         rsp_target_ff   <= redir_c ? ADDR_W'(target_c) : '0;
         rsp_ret_ff      <= ret_c;
         rsp_depth_ff    <= DEPTH_W'(sp_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         sp_ff            <= '0;
         lc_ff            <= '0;
         halted_ff        <= 1'b0;
         locals_in_use_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < LOCAL_SLOTS; i++) begin
            locals_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            locals_in_use_ff <= csr_wr_data;
         end
         if (commit) begin
            sp_ff        <= sp_in;
            lc_ff        <= lc_in;
            halted_ff    <= halted_in;
            rsp_valid_ff <= 1'b1;
            if (loc_we) begin
               locals_ff[loc_idx] <= loc_wdata;
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.redirect     = rsp_redirect_ff;
   assign rsp_ch.jump_target  = rsp_target_ff;
   assign rsp_ch.return_value = rsp_ret_ff;
   assign rsp_ch.depth_now    = rsp_depth_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= STACK_DEPTH) else $error("operand stack depth beyond bound");

   a_lc_bound: assert property (@(posedge clock) disable iff (reset)
      32'(lc_ff) <= LABEL_DEPTH) else $error("label count beyond bound");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("halt cleared without reset");

   a_halt_frozen: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && commit) |=> ($stable(sp_ff) && $stable(lc_ff)))
      else $error("state changed while halted");

   a_div_no_commit: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !commit) else $error("item finished while divider busy");

endmodule

>>> verif/testbench.sv
// self-checking testbench of the i32 stack executor: directed table, random programs, then a halting case
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wasm_pkg::*;

   localparam int STACK_SLOTS = 256;
   localparam int NUM_LOCALS  = 16;
   localparam int LABEL_SLOTS = 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] imm_value;
      logic [LIDX_W-1:0]        local_index;
      logic [LDEPTH_W-1:0]      label_depth;
      logic [ADDR_W-1:0]        end_addr;
      logic [ADDR_W-1:0]        loop_addr;
      logic [ADDR_W-1:0]        else_addr;
      logic                     has_else;
   } instr_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     redirect;
      logic [ADDR_W-1:0]        jump_target;
      logic signed [DATA_W-1:0] return_value;
      logic [DEPTH_W-1:0]       depth_now;
   } outcome_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  cont;
      logic [ADDR_W-1:0]  start;
      logic [DEPTH_W-1:0] height;
   } label_type;

   typedef struct {
      logic [DATA_W-1:0]  stk [STACK_SLOTS];
      logic [DEPTH_W-1:0] sp;
      logic [DATA_W-1:0]  locals [NUM_LOCALS];
      label_type          labels [LABEL_SLOTS];
      int                 nlab;
      bit                 halted;
      logic [CFG_W-1:0]   nlocals;
   } machine_type;

   typedef struct {
      instr_type   it;
      bit          typed;
      outcome_type want;
   } dir_row_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   wasm_req_if req_ch ();
   wasm_rsp_if rsp_ch ();

   wasm_i32_stack_executor u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source)
   );

   machine_type   machine;
   outcome_type   pending_outcomes [$];
   dir_row_type   dir_rows [$];
   int            fails;
   int            instrs_sent;
   int            outcomes_seen;
   int            burst_left;
   int            cycles;
   int            stall_left;
   int            ready_mode;
   int            peak_depth;
   int            peak_labels;
   int            halt_kind;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic take_return(inout machine_type s, inout outcome_type r);
      s.halted = 1'b1;
      r.status = STAT_RETURNED;
      r.return_value = (s.sp > 0) ? s.stk[s.sp-1] : '0;
   endtask

   task automatic push_label(inout machine_type s, inout outcome_type r,
                             input logic [KIND_W-1:0] kind,
                             input logic [ADDR_W-1:0] cont, input logic [ADDR_W-1:0] start,
                             output bit ok);
      ok = s.nlab < LABEL_SLOTS;
      if (ok) begin
         s.labels[s.nlab] = '{kind, cont, start, s.sp};
         s.nlab++;
      end else begin
         r.status = STAT_LABEL_OVF;
         s.halted = 1'b1;
      end
   endtask

   task automatic take_branch(inout machine_type s, inout outcome_type r, input int depth);
      int        idx;
      label_type e;
      if (depth >= s.nlab) begin
         take_return(s, r);
      end else begin
         idx = s.nlab - 1 - depth;
         e = s.labels[idx];
         r.redirect = 1'b1;
         r.jump_target = (e.kind == KIND_LOOP) ? e.start : e.cont;
         s.sp = e.height;
         s.nlab = idx + ((e.kind == KIND_LOOP) ? 1 : 0);
      end
   endtask

   task automatic exec_instr(inout machine_type s, input instr_type it, output outcome_type r);
      logic [DATA_W-1:0] cond, a, b, v;
      bit                lok, ok;
      r = '0;
      lok = (it.local_index < s.nlocals) && (it.local_index < NUM_LOCALS);
      if (!s.halted) begin
         case (it.op)
            OP_NOP: ;
            OP_TRAP: begin
               r.status = STAT_UNREACHABLE;
               s.halted = 1'b1;
            end
            OP_BLK: push_label(s, r, KIND_BLOCK, it.end_addr, it.loop_addr, ok);
            OP_LOOP: push_label(s, r, KIND_LOOP, it.end_addr, it.loop_addr, ok);
            OP_IF, OP_BR_COND: begin
               if (s.sp == 0) begin
                  r.status = STAT_COND_UNDER;
                  s.halted = 1'b1;
               end else begin
                  s.sp--;
                  cond = s.stk[s.sp];
                  if (it.op == OP_BR_COND) begin
                     if (cond != 0) take_branch(s, r, int'(it.label_depth));
                  end else if (cond != 0 || it.has_else) begin
                     push_label(s, r, KIND_IF, it.end_addr, '0, ok);
                     if (ok && cond == 0) begin
                        r.redirect = 1'b1;
                        r.jump_target = it.else_addr;
                     end
                  end else begin
                     r.redirect = 1'b1;
                     r.jump_target = it.end_addr;
                  end
               end
            end
            OP_ELSE: begin
               if (s.nlab > 0) begin
                  s.nlab--;
                  r.redirect = 1'b1;
                  r.jump_target = s.labels[s.nlab].cont;
               end
            end
            OP_END: begin
               if (s.nlab > 0) s.nlab--;
               else take_return(s, r);
            end
            OP_BR: take_branch(s, r, int'(it.label_depth));
            OP_RET: take_return(s, r);
            OP_DROP: if (s.sp > 0) s.sp--;
            OP_LGET: begin
               if (lok && s.sp < STACK_SLOTS) begin
                  s.stk[s.sp] = s.locals[it.local_index];
                  s.sp++;
               end
            end
            OP_LSET: begin
               if (lok && s.sp > 0) begin
                  s.sp--;
                  s.locals[it.local_index] = s.stk[s.sp];
               end
            end
            OP_LTEE: if (lok && s.sp > 0) s.locals[it.local_index] = s.stk[s.sp-1];
            OP_CONST: begin
               if (s.sp < STACK_SLOTS) begin
                  s.stk[s.sp] = it.imm_value;
                  s.sp++;
               end
            end
            OP_EQZ: if (s.sp > 0) s.stk[s.sp-1] = DATA_W'(s.stk[s.sp-1] == 0);
            OP_EQ, OP_NE, OP_LT_S, OP_GT_S, OP_LE_S, OP_GE_S, OP_ADD, OP_SUB, OP_MUL,
            OP_DIV_S, OP_REM_S, OP_AND, OP_OR: begin
               if (s.sp >= 2) begin
                  a = s.stk[s.sp-2];
                  b = s.stk[s.sp-1];
                  s.sp--;
                  case (it.op)
                     OP_EQ:   v = DATA_W'(a == b);
                     OP_NE:   v = DATA_W'(a != b);
                     OP_LT_S: v = DATA_W'($signed(a) < $signed(b));
                     OP_GT_S: v = DATA_W'($signed(a) > $signed(b));
                     OP_LE_S: v = DATA_W'($signed(a) <= $signed(b));
                     OP_GE_S: v = DATA_W'($signed(a) >= $signed(b));
                     OP_ADD:  v = a + b;
                     OP_SUB:  v = a - b;
                     OP_MUL:  v = a * b;
                     OP_AND:  v = a & b;
                     OP_OR:   v = a | b;
                     default: begin
                        if (b == 0) begin
                           v = '0;
                           r.status = STAT_DIV_ZERO;
                        end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                           v = (it.op == OP_DIV_S) ? 32'h8000_0000 : '0;
                        end else if (it.op == OP_DIV_S) begin
                           v = $signed(a) / $signed(b);
                        end else begin
                           v = $signed(a) % $signed(b);
                        end
                     end
                  endcase
                  s.stk[s.sp-1] = v;
               end
            end
            default: begin
               r.status = STAT_UNKNOWN_OP;
               s.halted = 1'b1;
            end
         endcase
      end
      r.depth_now = s.sp;
   endtask

   function automatic instr_type make_instr(logic [OP_W-1:0] op, logic [DATA_W-1:0] imm,
                                            int li, int ld, int ea, int la, int xa, bit he);
      instr_type it;
      it.op = op;
      it.imm_value = imm;
      it.local_index = LIDX_W'(li);
      it.label_depth = LDEPTH_W'(ld);
      it.end_addr = ADDR_W'(ea);
      it.loop_addr = ADDR_W'(la);
      it.else_addr = ADDR_W'(xa);
      it.has_else = he;
      return it;
   endfunction

   function automatic instr_type random_instr(int push_pct);
      instr_type it;
      logic [DATA_W-1:0] imm;
      case ($urandom_range(0, 7))
         0: imm = 32'h0;
         1: imm = 32'h1;
         2: imm = 32'hFFFF_FFFF;
         3: imm = 32'h8000_0000;
         4: imm = 32'h7FFF_FFFF;
         5: imm = $urandom_range(0, 20) - 10;
         default: imm = $urandom;
      endcase
      it = make_instr(OP_NOP, imm,
                      $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 31),
                      $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 63),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < push_pct) begin
         case ($urandom_range(0, 9))
            0: it.op = OP_LGET;
            1: it.op = OP_BLK;
            2: it.op = OP_LOOP;
            default: it.op = OP_CONST;
         endcase
      end else begin
         it.op = OP_W'($urandom_range(0, 28));
      end
      return it;
   endfunction

   task automatic pick_live_instr(input int push_pct, output instr_type it);
      machine_type trial;
      outcome_type scratch;
      do begin
         it = random_instr(push_pct);
         trial = machine;
         exec_instr(trial, it, scratch);
      end while (trial.halted);
   endtask

   task automatic send_instr(input instr_type it, input bit typed, input outcome_type typed_want);
      outcome_type want;
      int          gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= it.op;
      req_ch.imm_value   <= it.imm_value;
      req_ch.local_index <= it.local_index;
      req_ch.label_depth <= it.label_depth;
      req_ch.end_addr    <= it.end_addr;
      req_ch.loop_addr   <= it.loop_addr;
      req_ch.else_addr   <= it.else_addr;
      req_ch.has_else    <= it.has_else;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      exec_instr(machine, it, want);
      if (typed) want = typed_want;
      pending_outcomes.push_back(want);
      instrs_sent++;
      if (int'(machine.sp) > peak_depth) peak_depth = int'(machine.sp);
      if (machine.nlab > peak_labels) peak_labels = machine.nlab;
   endtask

   task automatic write_locals(input logic [CFG_W-1:0] value);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      machine.nlocals = value;
   endtask

   task automatic check_field(string fname, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch_outcomes
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         outcomes_seen++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected item status %0d depth %0d", $time, rsp_ch.status,
                     rsp_ch.depth_now);
            fails++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", want.status, rsp_ch.status);
            check_field("redirect", want.redirect, rsp_ch.redirect);
            check_field("jump_target", want.jump_target, rsp_ch.jump_target);
            check_field("return_value", want.return_value[31:0], rsp_ch.return_value[31:0]);
            check_field("depth_now", want.depth_now, rsp_ch.depth_now);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (ready_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 40);
            end
         endcase
         if ($urandom_range(0, 199) == 0) ready_mode = $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      instr_type it;
      int        locals_plan [5];
      int        push_plan [5];
      int        run_len [5];

      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_NOP;
      req_ch.imm_value   <= '0;
      req_ch.local_index <= '0;
      req_ch.label_depth <= '0;
      req_ch.end_addr    <= '0;
      req_ch.loop_addr   <= '0;
      req_ch.else_addr   <= '0;
      req_ch.has_else    <= 1'b0;
      machine.sp      = '0;
      machine.nlab    = 0;
      machine.halted  = 1'b0;
      machine.nlocals = '0;
      foreach (machine.stk[i]) machine.stk[i] = '0;
      foreach (machine.locals[i]) machine.locals[i] = '0;
      foreach (machine.labels[i]) machine.labels[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_locals(CFG_W'(NUM_LOCALS));

      dir_rows.push_back('{make_instr(OP_NOP, 0, 0, 0, 0, 0, 0, 0), 1,
                           '{STAT_OK, 1'b0, 16'h0, 32'sh0, 9'd0}});
      dir_rows.push_back('{make_instr(OP_CONST, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0), 1,
                           '{STAT_OK, 1'b0, 16'h0, 32'sh0, 9'd1}});
      dir_rows.push_back('{make_instr(OP_CONST, 32'h8000_0000, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_ADD, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_CONST, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_DIV_S, 0, 0, 0, 0, 0, 0, 0), 1,
                           '{STAT_DIV_ZERO, 1'b0, 16'h0, 32'sh0, 9'd1}});
      dir_rows.push_back('{make_instr(OP_CONST, 32'h8000_0000, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_CONST, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_DIV_S, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_CONST, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_REM_S, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_LTEE, 0, 15, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_LSET, 0, 31, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_LGET, 0, 15, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_EQZ, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_LT_S, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_BLK, 0, 0, 0, 16'hFFFF, 16'h1234, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_LOOP, 0, 0, 0, 16'h0, 16'hFFFF, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_CONST, 5, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_BR_COND, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_BR, 0, 0, 1, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_CONST, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_IF, 0, 0, 0, 16'hABCD, 0, 16'h5555, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_CONST, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      dir_rows.push_back('{make_instr(OP_IF, 0, 0, 0, 16'h4321, 0, 16'h0001, 1), 0, '0});
      dir_rows.push_back('{make_instr(OP_ELSE, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      foreach (dir_rows[i]) send_instr(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

      locals_plan = '{16, 0, 31, $urandom_range(1, 15), 16};
      push_plan   = '{45, 30, 85, 50, 40};
      run_len     = '{240, 220, 360, 220, 200};
      for (int p = 0; p < 5; p++) begin
         write_locals(CFG_W'(locals_plan[p]));
         repeat (run_len[p]) begin
            pick_live_instr(push_plan[p], it);
            send_instr(it, 0, '0);
         end
      end

      // finish with one halting case, then items that the halt must ignore
      halt_kind = $urandom_range(0, 5);
      it = random_instr(0);
      case (halt_kind)
         0: it.op = OP_TRAP;
         1: it.op = OP_W'($urandom_range(29, 31));
         2: it.op = OP_RET;
         3: begin
            it.op = OP_BLK;
            while (machine.nlab < LABEL_SLOTS) send_instr(it, 0, '0);
         end
         4: begin
            it.op = OP_DROP;
            while (machine.sp > 0) send_instr(it, 0, '0);
            it.op = $urandom_range(0, 1) ? OP_IF : OP_BR_COND;
         end
         default: begin
            it.op = OP_END;
            while (machine.nlab > 0) send_instr(it, 0, '0);
         end
      endcase
      send_instr(it, 0, '0);
      repeat (6) begin
         it = random_instr(0);
         it.op = OP_W'($urandom_range(0, 31));
         send_instr(it, 0, '0);
      end
      req_ch.valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d instructions driven, %0d results compared", instrs_sent, outcomes_seen);
      $display("peak stack depth %0d, peak label depth %0d, halting case %0d",
               peak_depth, peak_labels, halt_kind);
      if (fails == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
